/* rtl/tsg_pkg.sv */
// shared types, codes and constants of the triplet similarity gradient block
package tsg_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TRIPLET = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // gradient model codes
  typedef enum logic [1:0] {
    MODE_DIST  = 2'd0,
    MODE_INNER = 2'd1,
    MODE_REL   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD,
    ST_RDOUT,
    ST_SRD,
    ST_CALC,
    ST_SIG,
    ST_Y,
    ST_MUL,
    ST_DIV1,
    ST_DIV1W,
    ST_DIV2,
    ST_DIV2W,
    ST_GRD,
    ST_GWR
  } state_t;

  // divider request
  typedef struct packed {
    logic               start;
    logic [47:0]        num;
    logic signed [35:0] den;
  } div_req_t;

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
  localparam logic [16:0]        Q_ONE     = 17'd65536;
  localparam logic [35:0]        SIG_SAT   = 36'd524288;
  localparam logic [16:0]        SIG_TOP   = 17'd65514;

  // sigmoid samples at steps of 0.5, Q16.16
  function automatic logic [16:0] sig_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:    v = 17'd32768;
      5'd1:    v = 17'd40793;
      5'd2:    v = 17'd47911;
      5'd3:    v = 17'd53581;
      5'd4:    v = 17'd57724;
      5'd5:    v = 17'd60565;
      5'd6:    v = 17'd62428;
      5'd7:    v = 17'd63615;
      5'd8:    v = 17'd64357;
      5'd9:    v = 17'd64816;
      5'd10:   v = 17'd65097;
      5'd11:   v = 17'd65269;
      5'd12:   v = 17'd65374;
      5'd13:   v = 17'd65438;
      5'd14:   v = 17'd65476;
      5'd15:   v = 17'd65500;
      5'd16:   v = 17'd65514;
      default: v = 17'd65514;
    endcase
    return v;
  endfunction

endpackage

/* rtl/tsg_div.sv */
// bit-serial signed divider with 32-bit saturation and zero-denominator rule
module tsg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tsg_pkg::div_req_t  req,
  output logic               done,
  output logic signed [31:0] quo
);
  import tsg_pkg::*;

  logic               busy_r;
  logic               post_r;
  logic               done_r;
  logic [5:0]         cnt_r;
  logic [47:0]        num_r;
  logic [35:0]        rem_r;
  logic [35:0]        dmag_r;
  logic               neg_r;
  logic               nz_r;
  logic signed [31:0] quo_r;

  logic [36:0]        sh;
  logic               ge;
  logic [36:0]        diff;
  logic signed [31:0] quo_nxt;

  // one quotient bit per cycle
  always_comb begin
    sh   = {rem_r, num_r[47]};
    ge   = sh >= {1'b0, dmag_r};
    diff = sh - {1'b0, dmag_r};
  end

  // sign and saturation of the final quotient
  always_comb begin
    if (dmag_r == 36'd0) begin
      quo_nxt = nz_r ? INT32_MAX : 32'sd0;
    end else if (neg_r) begin
      quo_nxt = (num_r > 48'h0000_8000_0000) ? INT32_MIN : 32'(-num_r);
    end else begin
      quo_nxt = (num_r > 48'h0000_7FFF_FFFF) ? INT32_MAX : num_r[31:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      post_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          post_r <= 1'b1;
        end
      end else if (post_r) begin
        post_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r  <= req.num;
      rem_r  <= 36'd0;
      dmag_r <= req.den[35] ? 36'(-req.den) : 36'(req.den);
      neg_r  <= req.den[35];
      nz_r   <= req.num != 48'd0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[35:0] : sh[35:0];
      num_r <= {num_r[46:0], ge};
    end
    if (post_r) begin
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/triplet_similarity_gradient.sv */
// triplet similarity gradient: top level with similarity and gradient memories
// one item at a time; a read also waits while the output beat is stalled
// triplet: five similarity reads, then sigmoid steps (distance, inner product), divides, or neither (no model)
// (relative distance: two serial divides, each: start, 48 quotient bits, sign fix, done)
// memory reads are registered; each gradient update is a read then a write-back
// reset clears all NUM_OBJECTS squared gradient cells, in_stall high; mode 0
module triplet_similarity_gradient #(
  parameter int NUM_OBJECTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_row,
  input  logic [5:0]         in_col,
  input  logic signed [31:0] in_s_value,
  input  logic [5:0]         in_anchor,
  input  logic [5:0]         in_near_obj,
  input  logic [5:0]         in_far_obj,
  input  logic [30:0]        in_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_grad_value
);
  import tsg_pkg::*;

  localparam int IW    = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int DEPTH = NUM_OBJECTS * NUM_OBJECTS;
  localparam int AW    = $clog2(DEPTH);

  // index reduced modulo the object count
  function automatic logic [IW-1:0] mod_idx(input logic [5:0] v);
    logic [16:0] r;
    r = {11'd0, v};
    for (int k = 5; k >= 0; k--) begin
      if (r >= (17'(NUM_OBJECTS) << k)) r = r - (17'(NUM_OBJECTS) << k);
    end
    return r[IW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(AW'(r) * AW'(NUM_OBJECTS)) + AW'(c);
  endfunction

  // memories
  logic signed [31:0] sim_mem  [DEPTH];
  logic signed [31:0] grad_mem [DEPTH];
  logic signed [31:0] sim_q_r;
  logic signed [31:0] grad_q_r;

  // control state
  state_t      state_r, state_nxt;
  mode_t       mode_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic        out_valid_r;
  logic signed [31:0] out_grad_value_r;

  // item registers
  logic [AW-1:0] ld_addr_r;
  logic signed [31:0] s_val_r;
  logic [IW-1:0] x_r, a_r, b_r;
  logic [30:0]   w_r;

  // arithmetic registers
  logic signed [31:0] s_r [5];
  logic signed [35:0] t_r, dxa_r, dxb_r;
  logic        sat_r, neg_r;
  logic [16:0] base_r, y_r;
  logic [27:0] prod_r;
  logic [31:0] dl_r;
  logic signed [31:0] q1_r, q2_r;

  // strobes
  logic          accept;
  logic          sim_we, sim_re, grad_we, grad_re, out_load;
  logic [AW-1:0] sim_raddr, grad_raddr, grad_waddr;
  logic signed [31:0] grad_wdata;
  logic [AW-1:0] src_addr, dst_addr;
  logic signed [34:0] delta;
  logic signed [35:0] gsum;
  logic signed [31:0] gsat;
  div_req_t      div_req;
  logic          div_done;
  logic signed [31:0] div_quo;

  tsg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign accept = in_valid && !in_stall;

  // similarity read address for each of the five reads
  always_comb begin
    unique case (cnt_r)
      3'd0:    sim_raddr = cell_addr(x_r, x_r);
      3'd1:    sim_raddr = cell_addr(a_r, a_r);
      3'd2:    sim_raddr = cell_addr(b_r, b_r);
      3'd3:    sim_raddr = cell_addr(x_r, a_r);
      3'd4:    sim_raddr = cell_addr(x_r, b_r);
      default: sim_raddr = cell_addr(x_r, x_r);
    endcase
  end

  // gradient step addresses and deltas
  always_comb begin
    logic signed [34:0] d1, q1e, q2e;
    d1  = $signed({3'b000, dl_r});
    q1e = 35'(q1_r);
    q2e = 35'(q2_r);
    src_addr = cell_addr(x_r, a_r);
    dst_addr = cell_addr(x_r, a_r);
    delta    = 35'sd0;
    unique case (step_r)
      3'd0: begin
        delta = (mode_r == MODE_DIST) ? (d1 <<< 1) : (mode_r == MODE_INNER) ? d1 : q1e;
      end
      3'd1: begin
        src_addr = cell_addr(x_r, b_r);
        dst_addr = cell_addr(x_r, b_r);
        delta = (mode_r == MODE_DIST) ? -(d1 <<< 1) : (mode_r == MODE_INNER) ? -d1
              : q1e - q2e;
      end
      3'd2: begin
        src_addr = cell_addr(b_r, b_r);
        dst_addr = cell_addr(b_r, b_r);
        delta = d1;
      end
      3'd3: begin
        src_addr = cell_addr(a_r, a_r);
        dst_addr = cell_addr(a_r, a_r);
        delta = -d1;
      end
      3'd4: begin
        dst_addr = cell_addr(a_r, x_r);
      end
      3'd5: begin
        src_addr = cell_addr(x_r, b_r);
        dst_addr = cell_addr(b_r, x_r);
      end
      default: begin
      end
    endcase
  end

  // saturating add into the gradient
  always_comb begin
    gsum = 36'(grad_q_r) + 36'(delta);
    if (gsum > 36'(INT32_MAX)) gsat = INT32_MAX;
    else if (gsum < 36'(INT32_MIN)) gsat = INT32_MIN;
    else gsat = gsum[31:0];
  end

  // sequencer next state and strobes
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    in_stall   = (state_r != ST_IDLE) || clr_busy_r;
    sim_we     = 1'b0;
    sim_re     = 1'b0;
    grad_we    = 1'b0;
    grad_re    = 1'b0;
    grad_raddr = ld_addr_r;
    grad_waddr = ld_addr_r;
    grad_wdata = 32'sd0;
    out_load   = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = {w_r, 17'd0};
    div_req.den   = (state_r == ST_DIV1) ? (dxa_r + dxb_r) : dxb_r;
    if (clr_busy_r) begin
      grad_we    = 1'b1;
      grad_waddr = clr_addr_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_op))
            OP_LOAD:    state_nxt = ST_LOAD;
            OP_TRIPLET: begin
              state_nxt = ST_SRD;
              cnt_nxt   = 3'd0;
            end
            OP_READ:    state_nxt = ST_RD;
            OP_NONE:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        sim_we    = 1'b1;
        grad_we   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RD: begin
        grad_re   = 1'b1;
        state_nxt = ST_RDOUT;
      end
      ST_RDOUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SRD: begin
        sim_re  = cnt_r < 3'd5;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd5) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        step_nxt = 3'd0;
        unique case (mode_r)
          MODE_DIST, MODE_INNER: state_nxt = ST_SIG;
          MODE_REL:              state_nxt = ST_DIV1;
          MODE_NONE: begin
            state_nxt = ST_GRD;
            step_nxt  = 3'd4;
          end
        endcase
      end
      ST_SIG:  state_nxt = ST_Y;
      ST_Y:    state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_GRD;
      ST_DIV1: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV1W;
      end
      ST_DIV1W: if (div_done) state_nxt = ST_DIV2;
      ST_DIV2: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV2W;
      end
      ST_DIV2W: if (div_done) state_nxt = ST_GRD;
      ST_GRD: begin
        grad_re    = 1'b1;
        grad_raddr = src_addr;
        state_nxt  = ST_GWR;
      end
      ST_GWR: begin
        grad_we    = 1'b1;
        grad_waddr = dst_addr;
        grad_wdata = (step_r >= 3'd4) ? grad_q_r : gsat;
        if (step_r == 3'd5) begin
          state_nxt = ST_IDLE;
        end else begin
          step_nxt  = (step_r == 3'd1 && mode_r != MODE_DIST) ? 3'd4 : step_r + 3'd1;
          state_nxt = ST_GRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_DIST;
      cnt_r       <= 3'd0;
      step_r      <= 3'd0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      if (cfg_we) mode_r <= mode_t'(cfg_wdata);
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) clr_busy_r <= 1'b0;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // similarity memory
  always_ff @(posedge clk) begin
    if (sim_we) sim_mem[ld_addr_r] <= s_val_r;
    if (sim_re) sim_q_r <= sim_mem[sim_raddr];
  end

  // gradient memory
  always_ff @(posedge clk) begin
    if (grad_we) grad_mem[grad_waddr] <= grad_wdata;
    if (grad_re) grad_q_r <= grad_mem[grad_raddr];
  end

  // item capture, operand gathering and arithmetic
  always_ff @(posedge clk) begin
    logic [35:0] mag;
    logic [3:0]  ti;
    logic [12:0] stp;
    logic [16:0] yy;
    logic [47:0] m;
    mag = t_r[35] ? 36'(-t_r) : 36'(t_r);
    ti  = mag[18:15];
    stp = 13'(sig_tab({1'b0, ti} + 5'd1) - sig_tab({1'b0, ti}));
    yy  = base_r + 17'((prod_r + 28'd16384) >> 15);
    m   = 48'(w_r) * 48'(y_r) + 48'd32768;
    if (accept) begin
      ld_addr_r <= cell_addr(mod_idx(in_row), mod_idx(in_col));
      s_val_r   <= in_s_value;
      x_r       <= mod_idx(in_anchor);
      a_r       <= mod_idx(in_near_obj);
      b_r       <= mod_idx(in_far_obj);
      w_r       <= in_weight;
    end
    if (state_r == ST_SRD && cnt_r != 3'd0) s_r[cnt_r - 3'd1] <= sim_q_r;
    if (state_r == ST_CALC) begin
      if (mode_r == MODE_DIST) begin
        t_r <= 36'(s_r[1]) - 36'(s_r[2]) + (36'(s_r[4]) <<< 1) - (36'(s_r[3]) <<< 1);
      end else begin
        t_r <= 36'(s_r[4]) - 36'(s_r[3]);
      end
      dxa_r <= 36'(Q_ONE) + 36'(s_r[0]) + 36'(s_r[1]) - (36'(s_r[3]) <<< 1);
      dxb_r <= 36'(Q_ONE) + 36'(s_r[0]) + 36'(s_r[2]) - (36'(s_r[4]) <<< 1);
    end
    if (state_r == ST_SIG) begin
      sat_r  <= mag >= SIG_SAT;
      neg_r  <= t_r[35];
      base_r <= sig_tab({1'b0, ti});
      prod_r <= 28'(stp) * 28'(mag[14:0]);
    end
    if (state_r == ST_Y) begin
      y_r <= neg_r ? (Q_ONE - (sat_r ? SIG_TOP : yy)) : (sat_r ? SIG_TOP : yy);
    end
    if (state_r == ST_MUL) dl_r <= m[47:16];
    if (state_r == ST_DIV1W && div_done) q1_r <= div_quo;
    if (state_r == ST_DIV2W && div_done) q2_r <= div_quo;
    if (out_load) out_grad_value_r <= grad_q_r;
  end

  assign out_valid      = out_valid_r;
  assign out_grad_value = out_grad_value_r;

  // divider results arrive only while the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV1W || state_r == ST_DIV2W))
    else $error("divider result outside a wait state");

  // no item is worked on during the clearing sweep
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (state_r == ST_IDLE && in_stall))
    else $error("item in flight during gradient clear");

  // a read result waits while the output beat is held
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDOUT && out_valid_r && out_stall) |=> state_r == ST_RDOUT)
    else $error("read result overwrote a held beat");

endmodule
